// ----- rtl/exptok_pkg.sv -----
// Package for the expression tokenizer: token kinds, scan modes, character codes,
// the command record passed from the scanner front to the emitter back, and class helpers.
// No dependencies.
package exptok_pkg;

    localparam int CHAR_W          = 8;
    localparam int KIND_W          = 4;
    localparam int LEN_W           = 6;
    localparam int MAX_LEXEME_DEF  = 32;
    localparam int QUEUE_DEPTH     = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_INT     = 4'd0,
        KIND_ID      = 4'd1,
        KIND_ADDSUB  = 4'd2,
        KIND_INCDEC  = 4'd3,
        KIND_MULDIV  = 4'd4,
        KIND_ASSIGN  = 4'd5,
        KIND_LPAREN  = 4'd6,
        KIND_RPAREN  = 4'd7,
        KIND_AND     = 4'd8,
        KIND_OR      = 4'd9,
        KIND_XOR     = 4'd10,
        KIND_END     = 4'd11,
        KIND_ENDFILE = 4'd12,
        KIND_UNKNOWN = 4'd13
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_INT,
        MODE_ID,
        MODE_PLUS,
        MODE_MINUS
    } mode_t;

    // Where the characters of a token come from
    typedef enum logic [1:0] {
        SRC_EMPTY,  // one result, char 0, length 0
        SRC_ONE,    // one result, char from the command
        SRC_TWO,    // two results, same char twice
        SRC_STORE   // len results read from the lexeme store
    } src_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_FETCH,
        B_LOAD
    } back_state_t;

    typedef struct packed {
        src_t              src;
        kind_t             kind;
        logic [CHAR_W-1:0] ch;
        logic [LEN_W-1:0]  len;
        logic              bank;
    } cmd_t;

    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_AMP    = 8'h26;
    localparam logic [CHAR_W-1:0] CH_LPAR   = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAR   = 8'h29;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_USCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_BAR    = 8'h7C;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage

// ----- rtl/exptok_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module exptok_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/exptok_fifo.sv -----
// Short command queue between the scanner front and the emitter back.
// Depends on exptok_pkg (cmd_t, QUEUE_DEPTH).
module exptok_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  exptok_pkg::cmd_t  wdata,
    input  logic              pop,
    output exptok_pkg::cmd_t  rdata,
    output logic              full,
    output logic              empty
);
    import exptok_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    cmd_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign rdata = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/exptok_front.sv -----
// Scanner front: accepts characters, tracks the pending token, writes lexeme
// characters to the store and queues emit commands. Depends on exptok_pkg.
module exptok_front #(
    parameter int MAX_LEXEME = exptok_pkg::MAX_LEXEME_DEF,
    localparam int IDX_W = (MAX_LEXEME > 1) ? $clog2(MAX_LEXEME) : 1,
    localparam int CNT_W = $clog2(MAX_LEXEME + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [exptok_pkg::CHAR_W-1:0] in_char,
    input  logic                          in_eof,
    output logic                          ram_we,
    output logic [IDX_W:0]                ram_waddr,
    output logic [exptok_pkg::CHAR_W-1:0] ram_wdata,
    output logic                          q_push,
    output exptok_pkg::cmd_t              q_wdata,
    input  logic                          q_full,
    input  logic                          store_done
);
    import exptok_pkg::*;

    mode_t            mode_reg, mode_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             bank_reg, bank_next;
    logic             busy_reg, busy_next;
    logic             hold_valid_reg, hold_valid_next;
    cmd_t             hold_reg, hold_next;

    logic  accept;
    logic  in_token;
    logic  cont;
    logic  flush_en, tail_en, do_scan, scan_bank;
    cmd_t  flush_cmd, tail_cmd;

    assign in_token = (mode_reg == MODE_INT) || (mode_reg == MODE_ID);
    // A new token may write its first character to the other bank while the stored token drains
    assign in_ready = !hold_valid_reg && !q_full && !(busy_reg && in_token);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            cnt_reg        <= '0;
            bank_reg       <= 1'b0;
            busy_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            cnt_reg        <= cnt_next;
            bank_reg       <= bank_next;
            busy_reg       <= busy_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        bank_next = bank_reg;
        ram_we    = 1'b0;
        ram_waddr = {bank_reg, cnt_reg[IDX_W-1:0]};
        ram_wdata = in_char;
        flush_en  = 1'b0;
        tail_en   = 1'b0;
        do_scan   = 1'b0;
        scan_bank = bank_reg;
        cont      = 1'b0;

        // pending token as a command; a lone sign is one character
        flush_cmd.kind = (mode_reg == MODE_INT) ? KIND_INT :
                         (mode_reg == MODE_ID)  ? KIND_ID  : KIND_ADDSUB;
        flush_cmd.src  = in_token ? SRC_STORE : SRC_ONE;
        flush_cmd.ch   = (mode_reg == MODE_MINUS) ? CH_MINUS : CH_PLUS;
        flush_cmd.len  = in_token ? LEN_W'(cnt_reg) : LEN_W'(1);
        flush_cmd.bank = bank_reg;

        tail_cmd.src  = SRC_EMPTY;
        tail_cmd.kind = KIND_ENDFILE;
        tail_cmd.ch   = in_char;
        tail_cmd.len  = '0;
        tail_cmd.bank = bank_reg;

        if (accept)
        begin
            if (in_eof)
            begin
                flush_en  = (mode_reg != MODE_IDLE);
                tail_en   = 1'b1;
                mode_next = MODE_IDLE;
                cnt_next  = '0;
            end
            else
            begin
                case (mode_reg)
                    MODE_INT, MODE_ID:
                    begin
                        cont = (mode_reg == MODE_INT) ? is_digit(in_char) :
                               (is_letter(in_char) || is_digit(in_char) ||
                                (in_char == CH_USCORE));
                        if (cont && (cnt_reg < CNT_W'(MAX_LEXEME)))
                        begin
                            ram_we   = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                        end
                        else
                        begin
                            flush_en = 1'b1;
                            do_scan  = 1'b1;
                        end
                    end
                    MODE_PLUS, MODE_MINUS:
                    begin
                        if (in_char == flush_cmd.ch)
                        begin
                            tail_en      = 1'b1;
                            tail_cmd.src  = SRC_TWO;
                            tail_cmd.kind = KIND_INCDEC;
                            mode_next    = MODE_IDLE;
                            cnt_next     = '0;
                        end
                        else
                        begin
                            flush_en = 1'b1;
                            do_scan  = 1'b1;
                        end
                    end
                    default:
                    begin
                        do_scan = 1'b1;
                    end
                endcase
            end

            // a flushed stored token keeps its bank; the next one uses the other
            if (flush_en && in_token)
            begin
                scan_bank = !bank_reg;
                bank_next = !bank_reg;
            end

            if (do_scan)
            begin
                mode_next = MODE_IDLE;
                cnt_next  = '0;
                ram_waddr = {scan_bank, {IDX_W{1'b0}}};
                if (is_digit(in_char) || is_letter(in_char))
                begin
                    ram_we    = 1'b1;
                    cnt_next  = CNT_W'(1);
                    mode_next = is_digit(in_char) ? MODE_INT : MODE_ID;
                end
                else
                begin
                    case (in_char)
                        CH_SPACE, CH_TAB:
                        begin
                            tail_en = 1'b0;
                        end
                        CH_PLUS:
                        begin
                            mode_next = MODE_PLUS;
                        end
                        CH_MINUS:
                        begin
                            mode_next = MODE_MINUS;
                        end
                        CH_STAR, CH_SLASH:
                        begin
                            tail_en       = 1'b1;
                            tail_cmd.src  = SRC_ONE;
                            tail_cmd.kind = KIND_MULDIV;
                        end
                        CH_EQ:
                        begin
                            tail_en       = 1'b1;
                            tail_cmd.src  = SRC_ONE;
                            tail_cmd.kind = KIND_ASSIGN;
                        end
                        CH_LPAR:
                        begin
                            tail_en       = 1'b1;
                            tail_cmd.src  = SRC_ONE;
                            tail_cmd.kind = KIND_LPAREN;
                        end
                        CH_RPAR:
                        begin
                            tail_en       = 1'b1;
                            tail_cmd.src  = SRC_ONE;
                            tail_cmd.kind = KIND_RPAREN;
                        end
                        CH_AMP:
                        begin
                            tail_en       = 1'b1;
                            tail_cmd.src  = SRC_ONE;
                            tail_cmd.kind = KIND_AND;
                        end
                        CH_BAR:
                        begin
                            tail_en       = 1'b1;
                            tail_cmd.src  = SRC_ONE;
                            tail_cmd.kind = KIND_OR;
                        end
                        CH_CARET:
                        begin
                            tail_en       = 1'b1;
                            tail_cmd.src  = SRC_ONE;
                            tail_cmd.kind = KIND_XOR;
                        end
                        CH_NL:
                        begin
                            tail_en       = 1'b1;
                            tail_cmd.kind = KIND_END;
                        end
                        default:
                        begin
                            tail_en       = 1'b1;
                            tail_cmd.kind = KIND_UNKNOWN;
                        end
                    endcase
                end
            end
        end

        if (tail_cmd.src == SRC_ONE)
        begin
            tail_cmd.len = LEN_W'(1);
        end
        else if (tail_cmd.src == SRC_TWO)
        begin
            tail_cmd.len = LEN_W'(2);
        end
    end

    // Queue writes: a held second command goes first; otherwise the first command
    // of the accepted character (queue not full is part of ready).
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        busy_next       = busy_reg;
        q_push          = 1'b0;
        q_wdata         = flush_en ? flush_cmd : tail_cmd;

        if (hold_valid_reg)
        begin
            q_wdata = hold_reg;
            if (!q_full)
            begin
                q_push          = 1'b1;
                hold_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            q_push = flush_en || tail_en;
            if (flush_en && tail_en)
            begin
                hold_valid_next = 1'b1;
                hold_next       = tail_cmd;
            end
        end

        if (store_done)
        begin
            busy_next = 1'b0;
        end
        if (accept && flush_en && in_token)
        begin
            busy_next = 1'b1;
        end
    end

endmodule

// ----- rtl/exptok_back.sv -----
// Emitter back: pops commands and sends one result per lexeme character (a single one for
// an empty token) through a registered output stage. Depends on exptok_pkg.
module exptok_back #(
    parameter int MAX_LEXEME = exptok_pkg::MAX_LEXEME_DEF,
    localparam int IDX_W = (MAX_LEXEME > 1) ? $clog2(MAX_LEXEME) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  exptok_pkg::cmd_t              q_rdata,
    input  logic                          q_empty,
    output logic                          q_pop,
    output logic [IDX_W:0]                ram_raddr,
    input  logic [exptok_pkg::CHAR_W-1:0] ram_rdata,
    output logic                          store_done,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [exptok_pkg::CHAR_W-1:0] out_char,
    output logic                          out_last,
    output logic [exptok_pkg::KIND_W-1:0] out_kind,
    output logic [exptok_pkg::LEN_W-1:0]  out_len
);
    import exptok_pkg::*;

    back_state_t       state_reg, state_next;
    cmd_t              cur_reg, cur_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;
    logic [KIND_W-1:0] out_kind_reg, out_kind_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;

    logic              slot_free;
    logic              beat_last;
    logic [LEN_W-1:0]  beats;
    logic [CHAR_W-1:0] beat_char;

    assign ram_raddr = {cur_reg.bank, idx_reg[IDX_W-1:0]};
    assign slot_free = !out_valid_reg || out_ready;
    assign beats     = (cur_reg.src == SRC_EMPTY) ? LEN_W'(1) : cur_reg.len;
    assign beat_last = ((idx_reg + LEN_W'(1)) == beats);

    always_comb
    begin
        case (cur_reg.src)
            SRC_EMPTY: beat_char = '0;
            SRC_STORE: beat_char = ram_rdata;
            default:   beat_char = cur_reg.ch;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;
    assign out_kind  = out_kind_reg;
    assign out_len   = out_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        idx_reg      <= idx_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_kind_reg <= out_kind_next;
        out_len_reg  <= out_len_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_kind_next  = out_kind_reg;
        out_len_next   = out_len_reg;
        q_pop          = 1'b0;
        store_done     = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_rdata;
                    idx_next   = '0;
                    state_next = B_FETCH;
                end
            end
            B_FETCH:
            begin
                // store read address settles here; data is registered next cycle
                state_next = B_LOAD;
            end
            B_LOAD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = beat_char;
                    out_last_next  = beat_last;
                    out_kind_next  = beat_last ? cur_reg.kind : '0;
                    out_len_next   = beat_last ? cur_reg.len : '0;
                    if (beat_last)
                    begin
                        store_done = (cur_reg.src == SRC_STORE);
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + LEN_W'(1);
                        state_next = B_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/expression_tokenizer_top.sv -----
// Top level of the expression tokenizer: scanner front, command queue,
// emitter back and the two-bank lexeme store. Depends on exptok_pkg and all exptok_* modules.
//
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: char_code[7:0]; tuser: end_of_input
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: lexeme_char, lexeme_length;
//                                              tuser: token_kind; tlast: last
//
// Flow: the front takes a character whenever it is ready (two queue writes when a
//   token flush and a new result fall on the same character; the second is held). The
//   back pops a command in B_IDLE, then for each result steps through B_FETCH (store
//   read address) and B_LOAD (registered read data into the output register); it
//   pops the next command only after the last result of the current one.
// Stalls: the front stops while the queue is full, while a second command is
//   still held, and while an identifier or integer is being collected and the
//   previous stored token is still draining from the other store bank.
// Reset: rst_n clears all control state; the store needs no clearing pass.
module expression_tokenizer_top #(
    parameter int MAX_LEXEME = exptok_pkg::MAX_LEXEME_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic [0:0]  s_axis_tuser,   // [0] end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] lexeme_char, [13:8] lexeme_length, [15:14] zero
    output logic        m_axis_tlast,   // last result of a token
    output logic [3:0]  m_axis_tuser    // [3:0] token_kind
);
    import exptok_pkg::*;

    localparam int IDX_W = (MAX_LEXEME > 1) ? $clog2(MAX_LEXEME) : 1;

    // Store: two banks of 2**IDX_W characters, selected by the address MSB
    logic              ram_we;
    logic [IDX_W:0]    ram_waddr, ram_raddr;
    logic [CHAR_W-1:0] ram_wdata, ram_rdata;

    logic              q_push, q_pop, q_full, q_empty;
    cmd_t              q_wdata, q_rdata;
    logic              store_done;

    logic [CHAR_W-1:0] out_char;
    logic [LEN_W-1:0]  out_len;

    exptok_front #(
        .MAX_LEXEME (MAX_LEXEME)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_char    (s_axis_tdata),
        .in_eof     (s_axis_tuser[0]),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .q_push     (q_push),
        .q_wdata    (q_wdata),
        .q_full     (q_full),
        .store_done (store_done)
    );

    exptok_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    exptok_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (2 ** (IDX_W + 1))
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    exptok_back #(
        .MAX_LEXEME (MAX_LEXEME)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_rdata    (q_rdata),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .store_done (store_done),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_char   (out_char),
        .out_last   (m_axis_tlast),
        .out_kind   (m_axis_tuser),
        .out_len    (out_len)
    );

    assign m_axis_tdata = {2'b00, out_len, out_char};

endmodule
